[rtl/core/vgadl_pkg.sv]
// Shared types and constants for the VGA DAC/CRTC register block with dirty-line marks.
package vgadl_pkg;

    // Fixed field widths of the request and result beats
    localparam int OFF_W      = 17;
    localparam int PORT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int LINE_IDX_W = 10;
    localparam int ENTRY_W    = 8;

    // Request type codes
    localparam logic [2:0] REQ_PORT_WRITE     = 3'd0;
    localparam logic [2:0] REQ_PORT_READ      = 3'd1;
    localparam logic [2:0] REQ_VMEM_WRITE     = 3'd2;
    localparam logic [2:0] REQ_LINE_QUERY     = 3'd3;
    localparam logic [2:0] REQ_CLEAR_DIRTY    = 3'd4;
    localparam logic [2:0] REQ_PALETTE_LOOKUP = 3'd5;

    // Recognized I/O ports
    localparam logic [15:0] PORT_DAC_INDEX  = 16'h03C8;
    localparam logic [15:0] PORT_DAC_DATA   = 16'h03C9;
    localparam logic [15:0] PORT_CRTC_INDEX = 16'h03D4;
    localparam logic [15:0] PORT_CRTC_DATA  = 16'h03D5;

    // Port latch slots
    localparam logic [1:0] SLOT_DAC_INDEX  = 2'd0;
    localparam logic [1:0] SLOT_DAC_DATA   = 2'd1;
    localparam logic [1:0] SLOT_CRTC_INDEX = 2'd2;
    localparam logic [1:0] SLOT_CRTC_DATA  = 2'd3;

    // DAC color component sequence
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    // Decoded operation handed from the front to the back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DAC_INDEX,
        OP_DAC_DATA,
        OP_CRTC_INDEX,
        OP_CRTC_DATA,
        OP_PORT_READ,
        OP_VMEM_WRITE,
        OP_LINE_QUERY,
        OP_CLEAR,
        OP_LOOKUP
    } t_op;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] data;
        logic [OFF_W-1:0]  vmem_offset;
        logic [7:0]        query_line;
        logic [7:0]        color_index;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              line_is_dirty;
        logic              any_dirty;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              palette_done;
        logic              range_error;
    } t_rsp;

    // hit: line on screen, lookup entry in palette, or CRTC index in range
    typedef struct packed {
        t_op                   op;
        logic [1:0]            slot;
        logic [BYTE_W-1:0]     data;
        logic                  hit;
        logic [LINE_IDX_W-1:0] idx;
    } t_cmd;

endpackage

[rtl/core/vgadl_fifo.sv]
// Small synchronous queue of packed beats with an occupancy count.
module vgadl_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_data                        i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output t_data                        o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Wrap pointers at the last slot
    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/vgadl_front.sv]
// Front end: accepts request beats, decodes them into operations and computes line numbers.
module vgadl_front import vgadl_pkg::*; #(
    parameter int SCREEN_LINES    = 200,
    parameter int LINE_BYTES      = 320,
    parameter int CRTC_COUNT      = 19,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_req i_req,
    output logic o_cmd_push,
    output t_cmd o_cmd,
    input  logic i_cmd_full
);

    // Exact reciprocal for offset / LINE_BYTES over the whole offset range
    localparam int LB_LOG    = $clog2(LINE_BYTES);
    localparam int DIV_SHIFT = OFF_W + LB_LOG;
    localparam int PROD_W    = 2 * OFF_W + 1;
    localparam logic [OFF_W:0] DIV_MULT = (OFF_W + 1)'(
        ((64'd1 << DIV_SHIFT) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES));

    typedef logic [ENTRY_W-1:0] t_mod_tbl [256];

    // Byte modulo palette size, built by counting
    function automatic t_mod_tbl build_mod_tbl();
        t_mod_tbl tbl;
        int       rem;
        rem = 0;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = ENTRY_W'(rem);
            rem = (rem == PALETTE_ENTRIES - 1) ? 0 : rem + 1;
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod_tbl();

    logic [PROD_W-1:0] w_prod;
    logic [OFF_W-1:0]  w_quot;
    logic [OFF_W-1:0]  w_line;
    logic              w_line_hit;
    logic [1:0]        w_slot;
    logic              w_slot_hit;
    logic              w_take;
    t_cmd              n_cmd;
    t_cmd              r_cmd;
    logic              r_valid;

    // Line number of a video memory write or of a query
    assign w_prod     = PROD_W'(i_req.vmem_offset) * PROD_W'(DIV_MULT);
    assign w_quot     = OFF_W'(w_prod >> DIV_SHIFT);
    assign w_line     = (i_req.req_type == REQ_LINE_QUERY) ?
                        OFF_W'(i_req.query_line) : w_quot;
    assign w_line_hit = (w_line < OFF_W'(SCREEN_LINES));

    // Map port address to latch slot
    always_comb begin
        w_slot     = SLOT_DAC_INDEX;
        w_slot_hit = 1'b1;
        case (i_req.port)
            PORT_DAC_INDEX:  w_slot = SLOT_DAC_INDEX;
            PORT_DAC_DATA:   w_slot = SLOT_DAC_DATA;
            PORT_CRTC_INDEX: w_slot = SLOT_CRTC_INDEX;
            PORT_CRTC_DATA:  w_slot = SLOT_CRTC_DATA;
            default:         w_slot_hit = 1'b0;
        endcase
    end

    // Classify the request
    always_comb begin
        n_cmd      = '0;
        n_cmd.op   = OP_NOP;
        n_cmd.slot = w_slot;
        n_cmd.data = i_req.data;
        case (i_req.req_type)
            REQ_PORT_WRITE: begin
                if (w_slot_hit) begin
                    case (w_slot)
                        SLOT_DAC_INDEX: begin
                            n_cmd.op  = OP_DAC_INDEX;
                            n_cmd.idx = LINE_IDX_W'(MOD_TBL[i_req.data]);
                        end
                        SLOT_DAC_DATA: n_cmd.op = OP_DAC_DATA;
                        SLOT_CRTC_INDEX: begin
                            n_cmd.op  = OP_CRTC_INDEX;
                            n_cmd.hit = ({1'b0, i_req.data} < 9'(CRTC_COUNT));
                        end
                        default: n_cmd.op = OP_CRTC_DATA;
                    endcase
                end
            end
            REQ_PORT_READ: begin
                if (w_slot_hit) begin
                    n_cmd.op = OP_PORT_READ;
                end
            end
            REQ_VMEM_WRITE, REQ_LINE_QUERY: begin
                n_cmd.op  = (i_req.req_type == REQ_VMEM_WRITE) ? OP_VMEM_WRITE : OP_LINE_QUERY;
                n_cmd.hit = w_line_hit;
                n_cmd.idx = LINE_IDX_W'(w_line);
            end
            REQ_CLEAR_DIRTY: n_cmd.op = OP_CLEAR;
            REQ_PALETTE_LOOKUP: begin
                n_cmd.op  = OP_LOOKUP;
                n_cmd.hit = ({1'b0, i_req.color_index} < 9'(PALETTE_ENTRIES));
                n_cmd.idx = LINE_IDX_W'(i_req.color_index);
            end
            default: ;
        endcase
    end

    // Hold the decoded beat until the queue takes it
    assign o_full     = r_valid && i_cmd_full;
    assign w_take     = i_push && !o_full;
    assign o_cmd_push = r_valid && !i_cmd_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_cmd_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[rtl/core/vgadl_back.sv]
// Back end: executes decoded operations against the register state and forms result beats.
module vgadl_back import vgadl_pkg::*; #(
    parameter int SCREEN_LINES    = 200,
    parameter int CRTC_COUNT      = 19,
    parameter int PALETTE_ENTRIES = 256,
    parameter int OUT_DEPTH       = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  t_cmd                           i_cmd,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_rsp_push,
    output t_rsp                           o_rsp
);

    localparam int EW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int LW = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1;
    localparam int CW = (CRTC_COUNT > 1) ? $clog2(CRTC_COUNT) : 1;

    // Register state
    logic [BYTE_W-1:0]          r_latch [4];
    logic [BYTE_W-1:0]          r_crtc [CRTC_COUNT];
    logic [SCREEN_LINES-1:0]    r_marks;
    logic                       r_any;
    logic [EW-1:0]              r_dac_entry;
    logic [1:0]                 r_dac_comp;

    // Palette memories, zeroed by a clearing pass after reset
    logic [BYTE_W-1:0]          r_mem_red   [PALETTE_ENTRIES];
    logic [BYTE_W-1:0]          r_mem_green [PALETTE_ENTRIES];
    logic [BYTE_W-1:0]          r_mem_blue  [PALETTE_ENTRIES];
    logic                       r_clearing;
    logic [EW-1:0]              r_clr_idx;

    // Result stage
    logic                       r_w_valid;
    t_rsp                       r_w_rsp;
    logic                       r_w_lookup;
    logic [BYTE_W-1:0]          r_w_red;
    logic [BYTE_W-1:0]          r_w_green;
    logic [BYTE_W-1:0]          r_w_blue;

    logic                       w_issue;
    logic [1:0]                 w_comp;
    logic                       w_last_entry;
    logic                       w_sel_hit;
    logic [BYTE_W-1:0]          w_dac_byte;
    logic [EW-1:0]              w_pal_idx;
    logic [CW-1:0]              w_crtc_rd;
    logic [CW-1:0]              w_crtc_wr;
    logic [LW-1:0]              w_line_idx;
    logic [EW-1:0]              n_dac_entry;
    logic [1:0]                 n_dac_comp;
    logic                       n_any;
    t_rsp                       n_rsp;

    // Issue one beat a cycle outside the clearing pass while the result side has room
    assign w_issue   = !r_clearing && !i_cmd_empty &&
                       ((int'(i_out_count) + int'(r_w_valid)) < OUT_DEPTH);
    assign o_cmd_pop = w_issue;

    assign w_comp       = (r_dac_comp > COMP_BLUE) ? COMP_RED : r_dac_comp;
    assign w_last_entry = (r_dac_entry == EW'(PALETTE_ENTRIES - 1));
    assign w_sel_hit    = ({1'b0, r_latch[SLOT_CRTC_INDEX]} < 9'(CRTC_COUNT));
    assign w_dac_byte   = {i_cmd.data[5:0], 2'b00};
    assign w_pal_idx    = i_cmd.idx[EW-1:0];
    assign w_crtc_rd    = i_cmd.data[CW-1:0];
    assign w_crtc_wr    = r_latch[SLOT_CRTC_INDEX][CW-1:0];
    assign w_line_idx   = i_cmd.idx[LW-1:0];

    // Work out the next DAC position, dirty flag and result fields
    always_comb begin
        n_dac_entry = r_dac_entry;
        n_dac_comp  = r_dac_comp;
        n_any       = r_any;
        n_rsp       = '0;
        case (i_cmd.op)
            OP_DAC_INDEX: begin
                n_dac_entry = i_cmd.idx[EW-1:0];
                n_dac_comp  = COMP_RED;
            end
            OP_DAC_DATA: begin
                if (w_comp == COMP_BLUE) begin
                    n_dac_comp = COMP_RED;
                    if (w_last_entry) begin
                        n_dac_entry        = '0;
                        n_rsp.palette_done = 1'b1;
                    end else begin
                        n_dac_entry = r_dac_entry + 1'b1;
                    end
                end else begin
                    n_dac_comp = w_comp + 1'b1;
                end
            end
            OP_CRTC_INDEX: n_rsp.range_error = !i_cmd.hit;
            OP_CRTC_DATA:  n_rsp.range_error = !w_sel_hit;
            OP_PORT_READ:  n_rsp.read_data = r_latch[i_cmd.slot];
            OP_VMEM_WRITE: begin
                if (i_cmd.hit) begin
                    n_any = 1'b1;
                end
            end
            OP_LINE_QUERY: n_rsp.line_is_dirty = i_cmd.hit && r_marks[w_line_idx];
            OP_CLEAR:      n_any = 1'b0;
            default: ;
        endcase
        n_rsp.any_dirty = n_any;
    end

    // Update register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_latch[i] <= '0;
            end
            for (int i = 0; i < CRTC_COUNT; i++) begin
                r_crtc[i] <= '0;
            end
            r_marks     <= '0;
            r_any       <= 1'b0;
            r_dac_entry <= '0;
            r_dac_comp  <= COMP_RED;
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_w_valid   <= 1'b0;
        end else begin
            // Step the clearing pass over every palette entry
            if (r_clearing) begin
                if (r_clr_idx == EW'(PALETTE_ENTRIES - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            r_w_valid <= w_issue;
            if (w_issue) begin
                r_any       <= n_any;
                r_dac_entry <= n_dac_entry;
                r_dac_comp  <= n_dac_comp;
                case (i_cmd.op)
                    OP_DAC_INDEX: r_latch[SLOT_DAC_INDEX] <= i_cmd.data;
                    OP_DAC_DATA:  r_latch[SLOT_DAC_DATA]  <= i_cmd.data;
                    OP_CRTC_INDEX: begin
                        r_latch[SLOT_CRTC_INDEX] <= i_cmd.data;
                        r_latch[SLOT_CRTC_DATA]  <= i_cmd.hit ? r_crtc[w_crtc_rd] : '0;
                    end
                    OP_CRTC_DATA: begin
                        r_latch[SLOT_CRTC_DATA] <= i_cmd.data;
                        if (w_sel_hit) begin
                            r_crtc[w_crtc_wr] <= i_cmd.data;
                        end
                    end
                    OP_VMEM_WRITE: begin
                        if (i_cmd.hit) begin
                            r_marks[w_line_idx] <= 1'b1;
                        end
                    end
                    OP_CLEAR: r_marks <= '0;
                    default: ;
                endcase
            end
        end
    end

    // Write palette memories and register the lookup read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem_red[r_clr_idx]   <= '0;
            r_mem_green[r_clr_idx] <= '0;
            r_mem_blue[r_clr_idx]  <= '0;
        end else if (w_issue && (i_cmd.op == OP_DAC_DATA)) begin
            case (w_comp)
                COMP_RED:   r_mem_red[r_dac_entry]   <= w_dac_byte;
                COMP_GREEN: r_mem_green[r_dac_entry] <= w_dac_byte;
                default:    r_mem_blue[r_dac_entry]  <= w_dac_byte;
            endcase
        end
        if (w_issue) begin
            r_w_rsp    <= n_rsp;
            r_w_lookup <= (i_cmd.op == OP_LOOKUP) && i_cmd.hit;
            r_w_red    <= r_mem_red[w_pal_idx];
            r_w_green  <= r_mem_green[w_pal_idx];
            r_w_blue   <= r_mem_blue[w_pal_idx];
        end
    end

    // Drop color fields of results that are not a palette lookup hit
    always_comb begin
        o_rsp       = r_w_rsp;
        o_rsp.red   = r_w_lookup ? r_w_red   : '0;
        o_rsp.green = r_w_lookup ? r_w_green : '0;
        o_rsp.blue  = r_w_lookup ? r_w_blue  : '0;
    end

    assign o_rsp_push = r_w_valid;

endmodule

[rtl/core/vga_dac_crtc_dirty_line_regs_top.sv]
// VGA DAC palette, CRTC register and dirty-line block: top level with queues on both sides.
//
// Requests enter through push/full and every request yields exactly one result beat,
// read through empty/pop in request order. Outside the palette clearing pass and while
// results are popped, the block sustains one request per clock: a decode stage (which
// also derives the screen line from the video memory offset with a reciprocal multiply)
// feeds a four-entry command queue, a single execute stage owns all register state and
// applies one command per cycle, and a result stage that registers the palette memory
// read feeds a four-entry result queue. A result passes the decode register, the
// command queue, the result stage and the result queue on its way to the result ports.
// After reset the execute stage zeroes the palette memories in a clearing pass; five
// requests are taken meanwhile and then full holds off input until the pass ends. Line
// marks are flops cleared by reset.
module vga_dac_crtc_dirty_line_regs_top import vgadl_pkg::*; #(
    parameter int SCREEN_LINES    = 200,
    parameter int LINE_BYTES      = 320,
    parameter int CRTC_COUNT      = 19,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_req i_req,
    output logic empty,
    input  logic pop,
    output t_rsp o_rsp
);

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    logic                           w_cmd_push;
    t_cmd                           w_cmd_in;
    logic                           w_cmd_full;
    t_cmd                           w_cmd_head;
    logic                           w_cmd_empty;
    logic                           w_mid_pop;
    logic [$clog2(CMD_DEPTH+1)-1:0] w_mid_count;
    logic                           w_rsp_push;
    t_rsp                           w_rsp;
    logic                           w_out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] w_out_count;

    vgadl_front #(
        .SCREEN_LINES    (SCREEN_LINES),
        .LINE_BYTES      (LINE_BYTES),
        .CRTC_COUNT      (CRTC_COUNT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_req      (i_req),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in),
        .i_cmd_full (w_cmd_full)
    );

    vgadl_fifo #(
        .t_data (t_cmd),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_cmd_head),
        .o_empty (w_cmd_empty),
        .o_count (w_mid_count)
    );

    vgadl_back #(
        .SCREEN_LINES    (SCREEN_LINES),
        .CRTC_COUNT      (CRTC_COUNT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .OUT_DEPTH       (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_head),
        .o_cmd_pop   (w_mid_pop),
        .i_out_count (w_out_count),
        .o_rsp_push  (w_rsp_push),
        .o_rsp       (w_rsp)
    );

    vgadl_fifo #(
        .t_data (t_rsp),
        .DEPTH  (OUT_DEPTH)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rsp_push),
        .i_data  (w_rsp),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_rsp),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    // Result queue never sees a beat it has no room for
    a_no_rsp_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_push |-> !w_out_full)
        else $error("result beat pushed into a full result queue");

    // Every result beat comes from a command issued the cycle before
    a_rsp_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_push |-> $past(w_mid_pop))
        else $error("result beat without a preceding issue");

    // Execute never pops an empty command queue
    a_issue_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> (w_mid_count != '0))
        else $error("command issued from an empty queue");

    // Results in flight never exceed the result queue depth
    a_rsp_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(w_out_count) + int'(w_rsp_push)) <= OUT_DEPTH)
        else $error("result credit exceeded");

endmodule
